>>> sv/grid_successor_expand_defines.svh
// assertion macros for the grid successor expander
// expects clk_i and rst_ni in the scope of each use
`ifndef GRID_SUCCESSOR_EXPAND_DEFINES_SVH
`define GRID_SUCCESSOR_EXPAND_DEFINES_SVH

// consequence checked in the same cycle as the antecedent
`define GSE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// consequence checked in the cycle after the antecedent
`define GSE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/gse_pkg.sv
// shared types, codes and helper functions of the grid successor expander
// no dependencies
`default_nettype none

package gse_pkg;

  localparam int COORD_W       = 8;
  localparam int COST_W        = 32;
  localparam int CFG_W         = 9;
  localparam int CFG_IDX_W     = 2;
  localparam int NDIR          = 4;
  localparam int EXT_MAX       = 256;
  localparam int DEF_MAX_WIDTH  = 256;
  localparam int DEF_MAX_HEIGHT = 256;

  typedef enum logic {
    CMD_WRITE  = 1'b0,
    CMD_EXPAND = 1'b1
  } gse_cmd_e;

  typedef enum logic [1:0] {
    DIR_LEFT  = 2'd0,
    DIR_RIGHT = 2'd1,
    DIR_UP    = 2'd2,
    DIR_DOWN  = 2'd3
  } gse_dir_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_MODE   = 2'd2
  } gse_cfg_e;

  typedef struct packed {
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] x;
  } gse_xy_t;

  typedef struct packed {
    logic [CFG_W-1:0] width;
    logic [CFG_W-1:0] height;
    logic             mode;
  } gse_cfg_t;

  typedef struct packed {
    logic    en;
    gse_xy_t xy;
    logic    blk;
  } gse_map_wr_t;

  typedef struct packed {
    logic    en;
    gse_xy_t xy;
  } gse_map_rd_t;

  // expand request as taken from the input channel
  typedef struct packed {
    gse_xy_t           xy;
    logic [COST_W-1:0] cost;
  } gse_exp_t;

  // probed expand: child cost and the set of free in-grid neighbours
  typedef struct packed {
    gse_xy_t           xy;
    logic [COST_W-1:0] cost;
    logic              bad;
    logic [NDIR-1:0]   mask;
  } gse_item_t;

  function automatic logic in_grid(gse_xy_t xy, gse_cfg_t cfg);
    return ({1'b0, xy.x} < cfg.width) && ({1'b0, xy.y} < cfg.height);
  endfunction

  function automatic gse_xy_t neighbour(gse_xy_t xy, gse_dir_e d);
    gse_xy_t n;
    n = xy;
    case (d)
      DIR_LEFT:  n.x = xy.x - COORD_W'(1);
      DIR_RIGHT: n.x = xy.x + COORD_W'(1);
      DIR_UP:    n.y = xy.y - COORD_W'(1);
      DIR_DOWN:  n.y = xy.y + COORD_W'(1);
      default:   n = xy;
    endcase
    return n;
  endfunction

  // lowest set direction, left first
  function automatic gse_dir_e first_dir(logic [NDIR-1:0] mask);
    gse_dir_e d;
    d = DIR_DOWN;
    if (mask[DIR_UP])    d = DIR_UP;
    if (mask[DIR_RIGHT]) d = DIR_RIGHT;
    if (mask[DIR_LEFT])  d = DIR_LEFT;
    return d;
  endfunction

endpackage

`default_nettype wire

>>> sv/gse_map.sv
// obstacle bitmap: one-bit synchronous memory with a clearing sweep after reset
// depends on gse_pkg
`default_nettype none

module gse_map import gse_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  output logic             ready_o,
  input  wire gse_map_wr_t wr_i,
  input  wire gse_map_rd_t rd_i,
  output logic             rd_bit_o
);

  localparam int XLIM  = (MAX_WIDTH < EXT_MAX) ? MAX_WIDTH : EXT_MAX;
  localparam int YLIM  = (MAX_HEIGHT < EXT_MAX) ? MAX_HEIGHT : EXT_MAX;
  localparam int X_AW  = $clog2(XLIM);
  localparam int Y_AW  = $clog2(YLIM);
  localparam int AW    = X_AW + Y_AW;
  localparam int DEPTH = 1 << AW;

  logic          mem_q [DEPTH];
  logic          rd_bit_q;
  logic          clr_busy_q;
  logic [AW-1:0] clr_addr_q;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic          wr_bit;

  // sweep every entry to clear once after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_busy_q) begin
      clr_addr_q <= clr_addr_q + AW'(1);
      if (clr_addr_q == {AW{1'b1}}) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  always_comb begin
    if (clr_busy_q) begin
      wr_en   = 1'b1;
      wr_addr = clr_addr_q;
      wr_bit  = 1'b0;
    end else begin
      wr_en   = wr_i.en;
      wr_addr = {wr_i.xy.y[Y_AW-1:0], wr_i.xy.x[X_AW-1:0]};
      wr_bit  = wr_i.blk;
    end
  end

  assign rd_addr = {rd_i.xy.y[Y_AW-1:0], rd_i.xy.x[X_AW-1:0]};

  // read-first: a read and a write in the same cycle see the old bit
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_bit;
    end
    if (rd_i.en) begin
      rd_bit_q <= mem_q[rd_addr];
    end
  end

  assign ready_o  = !clr_busy_q;
  assign rd_bit_o = rd_bit_q;

endmodule

`default_nettype wire

>>> sv/gse_probe.sv
// probe unit: one map read per neighbour, gathers the free-neighbour mask
// depends on gse_pkg, reads through gse_map's port
`default_nettype none

module gse_probe import gse_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire gse_cfg_t    cfg_i,
  input  wire logic        load_i,
  input  wire gse_exp_t    exp_i,
  output logic             ready_o,
  output gse_map_rd_t      rd_o,
  input  wire logic        rd_bit_i,
  output gse_item_t        item_o,
  output logic             item_valid_o,
  input  wire logic        item_ready_i
);

  // probe stage
  logic              p_valid_q;
  gse_dir_e          p_idx_q;
  gse_xy_t           p_xy_q;
  logic [COST_W-1:0] p_cost_q;
  logic              p_bad_q;
  logic [NDIR-1:0]   p_ing_q;
  logic [1:0]        p_blk_q, p_blk_d;
  // result stage, waits on the down probe's read data
  logic              r_valid_q;
  gse_xy_t           r_xy_q;
  logic [COST_W-1:0] r_cost_q;
  logic              r_bad_q;
  logic [NDIR-1:0]   r_ing_q;
  logic [2:0]        r_blk_q;

  logic              p_step;
  logic              last_probe;
  logic              cell_in_grid;
  logic [COST_W:0]   sum;
  logic [COST_W-1:0] cost_sat;
  logic [NDIR-1:0]   ing;

  assign p_step     = p_valid_q && (!r_valid_q || item_ready_i);
  assign last_probe = p_step && (p_idx_q == DIR_DOWN);
  assign ready_o    = !p_valid_q || last_probe;

  assign rd_o.en = p_step;
  assign rd_o.xy = neighbour(p_xy_q, p_idx_q);

  // parent cost plus step cost, saturating
  always_comb begin
    cell_in_grid = in_grid(exp_i.xy, cfg_i);
    sum = {1'b0, exp_i.cost} +
          (cfg_i.mode ? {{(COST_W+1-COORD_W){1'b0}}, exp_i.xy.y} : (COST_W+1)'(1));
    cost_sat = sum[COST_W] ? {COST_W{1'b1}} : sum[COST_W-1:0];
    ing = '0;
    if (cell_in_grid) begin
      ing[DIR_LEFT]  = exp_i.xy.x != '0;
      ing[DIR_RIGHT] = ({1'b0, exp_i.xy.x} + CFG_W'(1)) < cfg_i.width;
      ing[DIR_UP]    = exp_i.xy.y != '0;
      ing[DIR_DOWN]  = ({1'b0, exp_i.xy.y} + CFG_W'(1)) < cfg_i.height;
    end
  end

  // read data lags its probe by one step
  always_comb begin
    p_blk_d = p_blk_q;
    case (p_idx_q)
      DIR_RIGHT: p_blk_d[0] = rd_bit_i;
      DIR_UP:    p_blk_d[1] = rd_bit_i;
      default:   p_blk_d = p_blk_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q <= 1'b0;
      p_idx_q   <= DIR_LEFT;
      r_valid_q <= 1'b0;
    end else begin
      if (load_i) begin
        p_valid_q <= 1'b1;
        p_idx_q   <= DIR_LEFT;
      end else if (last_probe) begin
        p_valid_q <= 1'b0;
      end else if (p_step) begin
        p_idx_q <= gse_dir_e'(p_idx_q + 2'd1);
      end
      if (last_probe) begin
        r_valid_q <= 1'b1;
      end else if (item_ready_i) begin
        r_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      p_xy_q   <= exp_i.xy;
      p_cost_q <= cost_sat;
      p_bad_q  <= !cell_in_grid;
      p_ing_q  <= ing;
    end else if (p_step) begin
      p_blk_q <= p_blk_d;
    end
    if (last_probe) begin
      r_xy_q   <= p_xy_q;
      r_cost_q <= p_cost_q;
      r_bad_q  <= p_bad_q;
      r_ing_q  <= p_ing_q;
      r_blk_q  <= {rd_bit_i, p_blk_q};
    end
  end

  assign item_valid_o = r_valid_q;
  assign item_o.xy    = r_xy_q;
  assign item_o.cost  = r_cost_q;
  assign item_o.bad   = r_bad_q;
  assign item_o.mask  = r_ing_q & ~{rd_bit_i, r_blk_q};

endmodule

`default_nettype wire

>>> sv/gse_emit.sv
// result register: walks the free-neighbour mask, one result per transaction
// depends on gse_pkg
`default_nettype none

module gse_emit import gse_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire gse_item_t    item_i,
  input  wire logic         item_valid_i,
  output logic              item_ready_o,
  output logic              o_valid_o,
  input  wire logic         o_ready_i,
  output gse_xy_t           o_xy_o,
  output logic [COST_W-1:0] o_cost_o,
  output logic              o_child_o,
  output logic              o_bad_o,
  output logic              o_last_o
);

  logic              o_valid_q;
  gse_xy_t           o_xy_q, o_xy_d;
  logic [COST_W-1:0] o_cost_q, o_cost_d;
  logic              o_child_q, o_child_d;
  logic              o_bad_q, o_bad_d;
  logic              o_last_q, o_last_d;
  logic [NDIR-1:0]   e_rem_q, e_rem_d;
  gse_xy_t           e_xy_q;
  logic [COST_W-1:0] e_cost_q;

  logic              load;
  logic              o_fire;
  logic [NDIR-1:0]   src_mask;
  gse_xy_t           src_xy;
  logic [COST_W-1:0] src_cost;
  logic              src_bad;
  gse_dir_e          d;

  assign o_fire       = o_valid_q && o_ready_i;
  assign item_ready_o = !o_valid_q || (o_ready_i && o_last_q);
  assign load         = item_valid_i && item_ready_o;

  always_comb begin
    src_mask = load ? item_i.mask : e_rem_q;
    src_xy   = load ? item_i.xy   : e_xy_q;
    src_cost = load ? item_i.cost : e_cost_q;
    src_bad  = load ? item_i.bad  : 1'b0;
    d        = first_dir(src_mask);
    e_rem_d  = src_mask & ~(NDIR'(1) << d);
    if (src_mask == '0) begin
      // no child or a cell outside the grid: one empty result
      o_xy_d    = '0;
      o_cost_d  = '0;
      o_child_d = 1'b0;
      o_bad_d   = src_bad;
      o_last_d  = 1'b1;
    end else begin
      o_xy_d    = neighbour(src_xy, d);
      o_cost_d  = src_cost;
      o_child_d = 1'b1;
      o_bad_d   = 1'b0;
      o_last_d  = e_rem_d == '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_valid_q <= 1'b0;
    end else if (load) begin
      o_valid_q <= 1'b1;
    end else if (o_fire && o_last_q) begin
      o_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load || (o_fire && !o_last_q)) begin
      o_xy_q    <= o_xy_d;
      o_cost_q  <= o_cost_d;
      o_child_q <= o_child_d;
      o_bad_q   <= o_bad_d;
      o_last_q  <= o_last_d;
      e_rem_q   <= e_rem_d;
    end
    if (load) begin
      e_xy_q   <= item_i.xy;
      e_cost_q <= item_i.cost;
    end
  end

  assign o_valid_o = o_valid_q;
  assign o_xy_o    = o_xy_q;
  assign o_cost_o  = o_cost_q;
  assign o_child_o = o_child_q;
  assign o_bad_o   = o_bad_q;
  assign o_last_o  = o_last_q;

endmodule

`default_nettype wire

>>> sv/grid_successor_expand.sv
// top level of the four-way grid successor expander
// depends on gse_pkg, gse_map, gse_probe, gse_emit and the assertion macro header
//
//  channel   direction  handshake             carries
//  s_axis    in         tvalid/tready         write or expand command
//  m_axis    out        tvalid/tready/tlast   one neighbour result per transaction
//  cfg       in         cfg_we_i              grid width, grid height, cost mode
//
// an expand occupies the probe unit for four neighbour reads through the
// single read port of the obstacle map; writes are taken once the probe unit frees
// up to four results leave at one per cycle while m_axis_tready is high
// after reset the map is swept clear, 2^(X_AW+Y_AW) entries (65536 at the default size),
// with s_axis_tready low; configuration writes are taken during the sweep
// a stalled m_axis backs up through the result stage into the probe unit
`default_nettype none

module grid_successor_expand import gse_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // configuration write port
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_W-1:0]     cfg_data_i,
  // input stream
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  // tdata: cell_x[7:0], cell_y[15:8], blocked[16], parent_cost[48:17], zero pad
  input  wire logic [55:0]          s_axis_tdata,
  // tuser: cmd
  input  wire logic                 s_axis_tuser,
  // result stream
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  // tdata: child_x[7:0], child_y[15:8], child_cost[47:16]
  output logic [47:0]               m_axis_tdata,
  // tuser: child_valid[0], bad_cell[1]
  output logic [1:0]                m_axis_tuser,
  output logic                      m_axis_tlast
);

  `include "grid_successor_expand_defines.svh"

  // extents above the map size or 256 are saturated on write
  localparam int WLIM_I = (MAX_WIDTH < EXT_MAX) ? MAX_WIDTH : EXT_MAX;
  localparam int HLIM_I = (MAX_HEIGHT < EXT_MAX) ? MAX_HEIGHT : EXT_MAX;
  localparam logic [CFG_W-1:0] W_LIM = CFG_W'(WLIM_I);
  localparam logic [CFG_W-1:0] H_LIM = CFG_W'(HLIM_I);

  logic [CFG_W-1:0] width_q;
  logic [CFG_W-1:0] height_q;
  logic             mode_q;
  gse_cfg_t         cfg;

  // input unpacking
  gse_cmd_e          in_cmd;
  gse_xy_t           in_xy;
  logic              in_blk;
  logic [COST_W-1:0] in_cost;
  logic              s_fire;
  logic              exp_load;
  gse_exp_t          exp_req;

  logic        map_ready;
  logic        probe_ready;
  gse_map_wr_t map_wr;
  gse_map_rd_t map_rd;
  logic        map_bit;

  gse_item_t   item;
  logic        item_valid;
  logic        item_ready;

  gse_xy_t           out_xy;
  logic [COST_W-1:0] out_cost;
  logic              out_child;
  logic              out_bad;

  // configuration registers, values kept already clamped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= W_LIM;
      height_q <= H_LIM;
      mode_q   <= 1'b0;
    end else if (cfg_we_i) begin
      case (gse_cfg_e'(cfg_idx_i))
        CFG_WIDTH:  width_q  <= (cfg_data_i > W_LIM) ? W_LIM : cfg_data_i;
        CFG_HEIGHT: height_q <= (cfg_data_i > H_LIM) ? H_LIM : cfg_data_i;
        CFG_MODE:   mode_q   <= cfg_data_i[0];
        default:    ; // unknown index, write dropped
      endcase
    end
  end

  assign cfg.width  = width_q;
  assign cfg.height = height_q;
  assign cfg.mode   = mode_q;

  assign in_cmd  = gse_cmd_e'(s_axis_tuser);
  assign in_xy.x = s_axis_tdata[7:0];
  assign in_xy.y = s_axis_tdata[15:8];
  assign in_blk  = s_axis_tdata[16];
  assign in_cost = s_axis_tdata[48:17];

  // one ready for both commands: a write landing on the edge of the last probe
  // still leaves that probe the old bit, matching the transaction order
  assign s_axis_tready = map_ready && probe_ready;
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign exp_load      = s_fire && (in_cmd == CMD_EXPAND);

  // writes outside the grid in use are dropped
  assign map_wr.en  = s_fire && (in_cmd == CMD_WRITE) && in_grid(in_xy, cfg);
  assign map_wr.xy  = in_xy;
  assign map_wr.blk = in_blk;

  assign exp_req.xy   = in_xy;
  assign exp_req.cost = in_cost;

  gse_map #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_map (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ready_o  (map_ready),
    .wr_i     (map_wr),
    .rd_i     (map_rd),
    .rd_bit_o (map_bit)
  );

  gse_probe u_probe (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .load_i       (exp_load),
    .exp_i        (exp_req),
    .ready_o      (probe_ready),
    .rd_o         (map_rd),
    .rd_bit_i     (map_bit),
    .item_o       (item),
    .item_valid_o (item_valid),
    .item_ready_i (item_ready)
  );

  gse_emit u_emit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (item),
    .item_valid_i (item_valid),
    .item_ready_o (item_ready),
    .o_valid_o    (m_axis_tvalid),
    .o_ready_i    (m_axis_tready),
    .o_xy_o       (out_xy),
    .o_cost_o     (out_cost),
    .o_child_o    (out_child),
    .o_bad_o      (out_bad),
    .o_last_o     (m_axis_tlast)
  );

  assign m_axis_tdata = {out_cost, out_xy.y, out_xy.x};
  assign m_axis_tuser = {out_bad, out_child};

  // nothing enters while the map is still being cleared
  `GSE_ASSERT_NOW(a_no_take_in_clear, !map_ready, !s_axis_tready, "transaction during map clear")
  // an empty result always closes its expand
  `GSE_ASSERT_NOW(a_empty_is_last, m_axis_tvalid && !m_axis_tuser[0], m_axis_tlast, "empty not last")
  // an out-of-grid expand never carries a child
  `GSE_ASSERT_NOW(a_bad_no_child, m_axis_tvalid && m_axis_tuser[1], !m_axis_tuser[0], "bad with child")
  // a probed item waiting on the result register keeps its mask and fields
  `GSE_ASSERT_NEXT(a_item_held, item_valid && !item_ready, item_valid && $stable(item), "item lost")

endmodule

`default_nettype wire

>>> tb/sv/gse_tb_pkg.sv
// scoreboard for the grid successor expander testbench: mirrors the obstacle map
// and grid registers, predicts neighbour results and checks them in order
// depends on gse_pkg
`default_nettype none

package gse_tb_pkg;
  import gse_pkg::*;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COST_W-1:0]  cost;
    logic               valid;
    logic               bad;
    logic               last;
  } child_result_t;

  class successor_scoreboard;
    bit               blocked_q [DEF_MAX_WIDTH*DEF_MAX_HEIGHT];
    logic [CFG_W-1:0] width_q;
    logic [CFG_W-1:0] height_q;
    logic             mode_q;
    child_result_t    expected_q [$];
    int               mismatches;
    int               results_checked;
    int               writes_noted;
    int               expands_noted;

    function new();
      width_q  = CFG_W'(EXT_MAX);
      height_q = CFG_W'(EXT_MAX);
      mode_q   = 1'b0;
    endfunction

    function void set_reg(gse_cfg_e idx, logic [CFG_W-1:0] v);
      case (idx)
        CFG_WIDTH:  width_q  = v;
        CFG_HEIGHT: height_q = v;
        CFG_MODE:   mode_q   = v[0];
        default:    ;
      endcase
    endfunction

    // register value clipped to the instance size and the coordinate range
    function int extent(logic [CFG_W-1:0] v, int lim);
      int e;
      e = int'(v);
      if (e > lim) e = lim;
      if (e > EXT_MAX) e = EXT_MAX;
      return e;
    endfunction

    function int grid_w();
      return extent(width_q, DEF_MAX_WIDTH);
    endfunction

    function int grid_h();
      return extent(height_q, DEF_MAX_HEIGHT);
    endfunction

    function bit is_free(int x, int y);
      return !blocked_q[y * DEF_MAX_WIDTH + x];
    endfunction

    // append one predicted result at the tail of the expected queue
    function void queue_result(child_result_t r);
      expected_q = {expected_q, r};
    endfunction

    function void note_input(gse_cmd_e cmd, logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                             logic blk, logic [COST_W-1:0] parent);
      int               w;
      int               h;
      int               xi;
      int               yi;
      bit               in_grid_c;
      logic [COST_W:0]  sum;
      logic [COST_W-1:0] cost;
      child_result_t    r;
      child_result_t    kids [$];
      w  = grid_w();
      h  = grid_h();
      xi = int'(x);
      yi = int'(y);
      in_grid_c = (xi < w) && (yi < h);
      if (cmd == CMD_WRITE) begin
        writes_noted++;
        if (in_grid_c) blocked_q[yi * DEF_MAX_WIDTH + xi] = blk;
        return;
      end
      expands_noted++;
      r = '0;
      if (!in_grid_c) begin
        r.bad  = 1'b1;
        r.last = 1'b1;
        queue_result(r);
        return;
      end
      sum  = {1'b0, parent} + (mode_q ? (COST_W+1)'(y) : (COST_W+1)'(1));
      cost = sum[COST_W] ? '1 : sum[COST_W-1:0];
      r.cost  = cost;
      r.valid = 1'b1;
      // left, right, up, down
      if (xi > 0 && is_free(xi - 1, yi)) begin
        r.x = x - 1'b1; r.y = y; kids = {kids, r};
      end
      if (xi + 1 < w && is_free(xi + 1, yi)) begin
        r.x = x + 1'b1; r.y = y; kids = {kids, r};
      end
      if (yi > 0 && is_free(xi, yi - 1)) begin
        r.x = x; r.y = y - 1'b1; kids = {kids, r};
      end
      if (yi + 1 < h && is_free(xi, yi + 1)) begin
        r.x = x; r.y = y + 1'b1; kids = {kids, r};
      end
      if (kids.size() == 0) begin
        r = '0;
        r.last = 1'b1;
        queue_result(r);
      end else begin
        kids[kids.size()-1].last = 1'b1;
        foreach (kids[i]) queue_result(kids[i]);
      end
    endfunction

    function bit field_differs(string name, logic [COST_W-1:0] e, logic [COST_W-1:0] a);
      if (a !== e) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, e, a);
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function void check_result(logic [47:0] data, logic [1:0] user, logic last);
      child_result_t e;
      bit            bad_any;
      results_checked++;
      if (expected_q.size() == 0) begin
        $error("result transaction with nothing expected (tdata 0x%0h)", data);
        mismatches++;
        return;
      end
      e = expected_q.pop_front();
      bad_any = 1'b0;
      bad_any |= field_differs("child_x", COST_W'(e.x), COST_W'(data[7:0]));
      bad_any |= field_differs("child_y", COST_W'(e.y), COST_W'(data[15:8]));
      bad_any |= field_differs("child_cost", e.cost, data[47:16]);
      bad_any |= field_differs("child_valid", COST_W'(e.valid), COST_W'(user[0]));
      bad_any |= field_differs("bad_cell", COST_W'(e.bad), COST_W'(user[1]));
      bad_any |= field_differs("last", COST_W'(e.last), COST_W'(last));
      if (bad_any) mismatches++;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

endpackage

`default_nettype wire

>>> tb/sv/tb_top.sv
// top of the grid successor expander testbench: drives obstacle writes and expands,
// changes the grid registers between phases and checks every result transaction
// depends on gse_pkg, gse_tb_pkg and grid_successor_expand
`default_nettype none

module tb_top;
  import gse_pkg::*;
  import gse_tb_pkg::*;

  localparam int    RESET_CYCLES = 8;
  localparam int    SETTLE       = 16;      // covers the probe and result stages
  localparam int    HOLD_CYCLES  = 400;     // one long receiver hold-off
  localparam int    DRAIN_LIMIT  = 50000;
  localparam int    NPHASE       = 9;
  // reset sweep plus a worst case run, taken many times over
  localparam longint RUN_LIMIT   = 64'd30_000_000;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i     = CFG_WIDTH;
  logic [CFG_W-1:0]     cfg_data_i    = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [55:0]          s_axis_tdata  = '0;
  logic                 s_axis_tuser  = CMD_WRITE;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [47:0]          m_axis_tdata;
  logic [1:0]           m_axis_tuser;
  logic                 m_axis_tlast;

  // idling in percent of cycles, set per phase
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  // long hold-off request from the stimulus side, served once by the receiver
  bit long_hold_en   = 1'b0;
  bit hold_used      = 1'b0;
  int hold_left      = 0;

  // cell around which local stimulus clusters
  logic [COORD_W-1:0] anchor_x = '0;
  logic [COORD_W-1:0] anchor_y = '0;

  successor_scoreboard sb;

  grid_successor_expand DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #5 clk_i = ~clk_i;

  // result side: check each accepted transaction, then pick the next tready
  always @(posedge clk_i) begin : recv_side
    logic ready_nxt;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      sb.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
    end
    if (hold_left > 0) begin
      hold_left--;
      ready_nxt = 1'b0;
    end else if (long_hold_en && !hold_used) begin
      // start the long hold-off while the sender keeps offering items
      hold_used = 1'b1;
      hold_left = HOLD_CYCLES;
      ready_nxt = 1'b0;
    end else begin
      ready_nxt = ($urandom_range(99) >= recv_stall_pct);
    end
    m_axis_tready <= ready_nxt;
  end

  // one input transaction, with random idle cycles in front of it
  task automatic send_item(gse_cmd_e cmd, logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                           logic blk, logic [COST_W-1:0] cost);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'b0, cost, blk, y, x};
    s_axis_tuser  <= cmd;
    do @(posedge clk_i); while (s_axis_tready !== 1'b1);
    sb.note_input(cmd, x, y, blk, cost);
  endtask

  task automatic write_cell(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y, logic blk);
    send_item(CMD_WRITE, x, y, blk, '0);
  endtask

  task automatic expand_cell(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                             logic [COST_W-1:0] cost);
    send_item(CMD_EXPAND, x, y, 1'b0, cost);
  endtask

  // stop offering and wait until every expected result is back or DRAIN_LIMIT runs out,
  // then let the block finish any write still in flight
  task automatic drain();
    int n;
    n = 0;
    s_axis_tvalid <= 1'b0;
    while (sb.pending() > 0 && n < DRAIN_LIMIT) begin
      @(posedge clk_i);
      n++;
    end
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // all three registers, one write per cycle, only while the block is idle
  task automatic set_grid(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h, logic mode);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_WIDTH;
    cfg_data_i <= w;
    @(posedge clk_i);
    sb.set_reg(CFG_WIDTH, w);
    cfg_idx_i  <= CFG_HEIGHT;
    cfg_data_i <= h;
    @(posedge clk_i);
    sb.set_reg(CFG_HEIGHT, h);
    cfg_idx_i  <= CFG_MODE;
    cfg_data_i <= CFG_W'(mode);
    @(posedge clk_i);
    sb.set_reg(CFG_MODE, CFG_W'(mode));
    cfg_we_i   <= 1'b0;
  endtask

  // corners, boxed-in and blocked cells, out-of-grid cells, saturation, clamping
  task automatic directed_items();
    // corners at the reset size, the second one saturating
    expand_cell(8'd0, 8'd0, 32'd0);
    expand_cell(8'd255, 8'd255, 32'hFFFF_FFFF);
    // wall in a cell on all four sides
    write_cell(8'd4, 8'd5, 1'b1);
    write_cell(8'd6, 8'd5, 1'b1);
    write_cell(8'd5, 8'd4, 1'b1);
    write_cell(8'd5, 8'd6, 1'b1);
    expand_cell(8'd5, 8'd5, 32'd7);
    // an obstacle may itself be expanded
    write_cell(8'd10, 8'd10, 1'b1);
    expand_cell(8'd10, 8'd10, 32'd100);
    expand_cell(8'd11, 8'd10, 32'h7FFF_FFFF);
    // clearing an obstacle frees it again
    write_cell(8'd4, 8'd5, 1'b0);
    expand_cell(8'd5, 8'd5, 32'd1);
    drain();
    // small grid in row cost mode
    set_grid(9'd16, 9'd8, 1'b1);
    write_cell(8'd20, 8'd3, 1'b1);          // outside, ignored
    expand_cell(8'd20, 8'd3, 32'd9);
    expand_cell(8'd3, 8'd8, 32'd9);
    expand_cell(8'd15, 8'd7, 32'hFFFF_FFFA);
    expand_cell(8'd0, 8'd0, 32'd5);         // row 0 adds nothing
    drain();
    // zero width leaves no cell inside
    set_grid(9'd0, 9'd300, 1'b0);
    expand_cell(8'd0, 8'd0, 32'd1);
    drain();
    // oversized registers clamp; earlier obstacles keep their cells
    set_grid(9'd300, 9'd511, 1'b0);
    expand_cell(8'd255, 8'd255, 32'd3);
    expand_cell(8'd5, 8'd5, 32'd11);
    expand_cell(8'd21, 8'd3, 32'd0);
    drain();
  endtask

  task automatic random_item();
    int                 w;
    int                 h;
    gse_cmd_e           cmd;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic               blk;
    logic [COST_W-1:0]  cost;
    w   = sb.grid_w();
    h   = sb.grid_h();
    cmd = ($urandom_range(99) < 35) ? CMD_WRITE : CMD_EXPAND;
    x   = COORD_W'($urandom());
    y   = COORD_W'($urandom());
    if ($urandom_range(99) < 40) begin
      // near the last cell, so that obstacles and expands meet
      x = anchor_x + COORD_W'($urandom_range(4)) - COORD_W'(2);
      y = anchor_y + COORD_W'($urandom_range(4)) - COORD_W'(2);
    end else begin
      if (w > 0 && $urandom_range(99) < 88) x = COORD_W'($urandom_range(w - 1));
      if (h > 0 && $urandom_range(99) < 88) y = COORD_W'($urandom_range(h - 1));
    end
    anchor_x = x;
    anchor_y = y;
    blk = ($urandom_range(99) < 60);
    case ($urandom_range(7))
      0:       cost = 32'hFFFF_FFFF - COST_W'($urandom_range(300));
      1:       cost = COST_W'($urandom_range(3));
      default: cost = COST_W'($urandom());
    endcase
    send_item(cmd, x, y, blk, cost);
  endtask

  initial begin : stimulus
    logic [CFG_W-1:0] ph_w      [NPHASE];
    logic [CFG_W-1:0] ph_h      [NPHASE];
    logic             ph_mode   [NPHASE];
    int               ph_send   [NPHASE];
    int               ph_recv   [NPHASE];
    int               ph_items  [NPHASE];
    sb = new();
    // grid settings and idling profile of each random phase
    ph_w    = '{9'd8, 9'd1, 9'd256, 9'd13, 9'd2,   9'd511, 9'd256, 9'd6, 9'd0};
    ph_h    = '{9'd8, 9'd1, 9'd256, 9'd5,  9'd256, 9'd3,   9'd1,   9'd9, 9'd17};
    ph_mode = '{1'b0, 1'b1, 1'b1,   1'b0,  1'b1,   1'b0,   1'b1,   1'b0, 1'b0};
    ph_send = '{0,    50,   0,      28,    0,      50,     0,      28,   0};
    ph_recv = '{0,    0,    50,     28,    0,      0,      50,     28,   0};
    ph_items = '{50,  20,   50,     60,    50,     50,     40,     60,   20};

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    // the input stays stalled through the clearing sweep after reset
    directed_items();

    for (int p = 0; p < NPHASE; p++) begin
      set_grid(ph_w[p], ph_h[p], ph_mode[p]);
      send_idle_pct  = ph_send[p];
      recv_stall_pct = ph_recv[p];
      // in the first mixed phase the receiver stops for a long stretch
      if (p == 3) long_hold_en = 1'b1;
      for (int i = 0; i < ph_items[p]; i++) begin
        // sender pause in mid phase until the results have caught up
        if (p == 7 && i == 30) drain();
        random_item();
      end
      drain();
    end
    send_idle_pct  = 0;
    recv_stall_pct = 0;

    if (sb.pending() != 0) begin
      $error("%0d expected results never arrived", sb.pending());
      sb.mismatches++;
    end
    $display("covered %0d obstacle writes and %0d expands over %0d grid settings,",
             sb.writes_noted, sb.expands_noted, NPHASE + 4);
    $display("with %0d result transactions checked under four idling profiles",
             sb.results_checked);
    if (sb.mismatches == 0) begin
      $display("** grid_successor_expand: PASSED **");
    end else begin
      $display("** grid_successor_expand: FAILED **");
    end
    $finish;
  end

  // watchdog on the whole run
  initial begin : watchdog
    #(RUN_LIMIT);
    $display("** grid_successor_expand: FAILED **");
    $finish;
  end

endmodule

`default_nettype wire

>>> sim.f
+incdir+sv
sv/gse_pkg.sv
sv/gse_map.sv
sv/gse_probe.sv
sv/gse_emit.sv
sv/grid_successor_expand.sv
tb/sv/gse_tb_pkg.sv
tb/sv/tb_top.sv
